### hw/rtl/ssh_pkg.sv
package ssh_pkg;

   // frame counter width; the counter itself holds one more bit to saturate at 2^N
   localparam int FRAME_INDEX_BITS = 24;
   localparam int COUNT_BITS       = FRAME_INDEX_BITS + 1;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   // compare width that holds both a frame count and a 16-bit register
   localparam int CMP_BITS      = (COUNT_BITS > CSR_DATA_BITS) ? COUNT_BITS : CSR_DATA_BITS;
   // padded end is kept unclamped, so it needs one bit of headroom
   localparam int HELD_END_BITS = CMP_BITS + 1;

   // event queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = QUEUE_PTR_BITS + 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SILENCE       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SPEECH        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD               = 3'd4;

   // register reset values
   localparam logic [CSR_DATA_BITS-1:0] START_THRESHOLD_RESET   = 16'd16384;
   localparam logic [CSR_DATA_BITS-1:0] RELEASE_THRESHOLD_RESET = 16'd11469;
   localparam logic [CSR_DATA_BITS-1:0] MIN_SILENCE_RESET       = 16'd10;
   localparam logic [CSR_DATA_BITS-1:0] MIN_SPEECH_RESET        = 16'd8;
   localparam logic [CSR_DATA_BITS-1:0] PAD_RESET               = 16'd3;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] start_threshold;
      logic [CSR_DATA_BITS-1:0] release_threshold;
      logic [CSR_DATA_BITS-1:0] min_silence_frames;
      logic [CSR_DATA_BITS-1:0] min_speech_frames;
      logic [CSR_DATA_BITS-1:0] pad_frames;
   } cfg_type;

   // one classified frame event: a closed raw segment and/or the end of stream
   typedef struct packed {
      logic                        has_close;
      logic                        final_frame;
      logic [FRAME_INDEX_BITS-1:0] seg_begin;
      logic [COUNT_BITS-1:0]       seg_stop;
      logic [COUNT_BITS-1:0]       frame_count;
   } event_type;

   typedef struct packed {
      logic [FRAME_INDEX_BITS-1:0] seg_start;
      logic [COUNT_BITS-1:0]       seg_end;
      logic                        has_segment;
      logic                        reaches_stream_end;
      logic                        end_of_stream;
   } result_type;

endpackage

### hw/rtl/speech_segment_hysteresis_padder.sv
// Channel   Direction  Handshake             Payload
// req_      in         push / full           probability, final_frame
// rsp_      out        empty / pop           seg_start, seg_end, has_segment,
//                                            reaches_stream_end, end_of_stream
// csr_      in         csr_valid / csr_ready csr_index, csr_data
//
// The front takes one request per cycle while full is low and classifies it in
// that cycle; frames that close a segment or end the stream go into a 4-entry
// event queue. The back retires one event per cycle while its output register
// is free, a closing final frame as a close and then a flush; each result sits
// in one output register until popped. Synchronous reset clears stream state and
// loads the register defaults. full rises when the event queue fills: behind a
// stalled result, or under a run of final frames that each also close a segment.
module speech_segment_hysteresis_padder
   import ssh_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [CSR_DATA_BITS-1:0]    req_probability,
   input  logic                        req_final_frame,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [FRAME_INDEX_BITS-1:0] rsp_seg_start,
   output logic [COUNT_BITS-1:0]       rsp_seg_end,
   output logic                        rsp_has_segment,
   output logic                        rsp_reaches_stream_end,
   output logic                        rsp_end_of_stream,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data
);

   cfg_type    cfg_ff;
   logic       req_accept;
   logic       front_ev_valid;
   event_type  front_ev;
   logic       queue_empty;
   event_type  queue_head;
   logic       back_pop;
   logic       back_valid;
   result_type back_rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold    <= START_THRESHOLD_RESET;
         cfg_ff.release_threshold  <= RELEASE_THRESHOLD_RESET;
         cfg_ff.min_silence_frames <= MIN_SILENCE_RESET;
         cfg_ff.min_speech_frames  <= MIN_SPEECH_RESET;
         cfg_ff.pad_frames         <= PAD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_THRESHOLD:   cfg_ff.start_threshold    <= csr_data;
            CSR_RELEASE_THRESHOLD: cfg_ff.release_threshold  <= csr_data;
            CSR_MIN_SILENCE:       cfg_ff.min_silence_frames <= csr_data;
            CSR_MIN_SPEECH:        cfg_ff.min_speech_frames  <= csr_data;
            CSR_PAD:               cfg_ff.pad_frames         <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_accept = req_push & ~req_full;

   ssh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (req_accept),
      .probability (req_probability),
      .final_frame (req_final_frame),
      .ev_valid    (front_ev_valid),
      .ev          (front_ev)
   );

   ssh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept & front_ev_valid),
      .push_data (front_ev),
      .full      (req_full),
      .pop       (back_pop),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   ssh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ev_valid  (~queue_empty),
      .ev        (queue_head),
      .ev_pop    (back_pop),
      .rsp_valid (back_valid),
      .rsp       (back_rsp),
      .rsp_taken (rsp_pop & back_valid)
   );

   assign rsp_empty              = ~back_valid;
   assign rsp_seg_start          = back_rsp.seg_start;
   assign rsp_seg_end            = back_rsp.seg_end;
   assign rsp_has_segment        = back_rsp.has_segment;
   assign rsp_reaches_stream_end = back_rsp.reaches_stream_end;
   assign rsp_end_of_stream      = back_rsp.end_of_stream;

endmodule

### hw/rtl/ssh_front.sv
module ssh_front
   import ssh_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        accept,
   input  logic [CSR_DATA_BITS-1:0]    probability,
   input  logic                        final_frame,
   output logic                        ev_valid,
   output event_type                   ev
);

   logic [COUNT_BITS-1:0]       frame_index_ff, frame_index_in;
   logic                        in_speech_ff, in_speech_in;
   logic                        in_silence_ff, in_silence_in;
   logic [FRAME_INDEX_BITS-1:0] speech_begin_ff, speech_begin_in;
   logic [FRAME_INDEX_BITS-1:0] silence_begin_ff, silence_begin_in;

   logic [FRAME_INDEX_BITS-1:0] frame;
   logic [FRAME_INDEX_BITS-1:0] silence_gap;
   logic                        start_hit;
   logic                        release_hit;
   logic                        silence_done;

   assign start_hit    = probability >= cfg.start_threshold;
   assign release_hit  = probability < cfg.release_threshold;
   assign silence_gap  = frame - silence_begin_ff;
   assign silence_done = CMP_BITS'(silence_gap) >= CMP_BITS'(cfg.min_silence_frames);

   // frame number with saturation, hysteresis update, end-of-stream close
   always_comb begin
      if (!frame_index_ff[FRAME_INDEX_BITS]) begin
         frame          = frame_index_ff[FRAME_INDEX_BITS-1:0];
         frame_index_in = frame_index_ff + COUNT_BITS'(1);
      end else begin
         frame          = '1;
         frame_index_in = frame_index_ff;
      end

      in_speech_in     = in_speech_ff;
      in_silence_in    = in_silence_ff;
      speech_begin_in  = speech_begin_ff;
      silence_begin_in = silence_begin_ff;

      ev.has_close   = 1'b0;
      ev.final_frame = final_frame;
      ev.seg_begin   = speech_begin_ff;
      ev.seg_stop    = {1'b0, silence_begin_ff};
      ev.frame_count = frame_index_in;

      priority if (!in_speech_ff) begin
         if (start_hit) begin
            in_speech_in    = 1'b1;
            speech_begin_in = frame;
         end
      end else if (start_hit) begin
         in_silence_in = 1'b0;
      end else if (!in_silence_ff) begin
         if (release_hit) begin
            in_silence_in    = 1'b1;
            silence_begin_in = frame;
         end
      end else begin
         // silence long enough: close the segment at its start
         if (silence_done) begin
            ev.has_close  = 1'b1;
            in_speech_in  = 1'b0;
            in_silence_in = 1'b0;
         end
      end

      // last frame: close an open segment, then start a fresh stream
      if (final_frame) begin
         if (in_speech_in) begin
            ev.has_close = 1'b1;
            ev.seg_begin = speech_begin_in;
            ev.seg_stop  = in_silence_in ? {1'b0, silence_begin_in} : frame_index_in;
         end
         frame_index_in   = '0;
         in_speech_in     = 1'b0;
         in_silence_in    = 1'b0;
         speech_begin_in  = '0;
         silence_begin_in = '0;
      end
   end

   assign ev_valid = ev.has_close | ev.final_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff   <= '0;
         in_speech_ff     <= 1'b0;
         in_silence_ff    <= 1'b0;
         speech_begin_ff  <= '0;
         silence_begin_ff <= '0;
      end else if (accept) begin
         frame_index_ff   <= frame_index_in;
         in_speech_ff     <= in_speech_in;
         in_silence_ff    <= in_silence_in;
         speech_begin_ff  <= speech_begin_in;
         silence_begin_ff <= silence_begin_in;
      end
   end

endmodule

### hw/rtl/ssh_queue.sv
module ssh_queue
   import ssh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output event_type head
);

   event_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ssh_back.sv
module ssh_back
   import ssh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       ev_valid,
   input  event_type  ev,
   output logic       ev_pop,
   output logic       rsp_valid,
   output result_type rsp,
   input  logic       rsp_taken
);

   logic                        held_valid_ff, held_valid_in;
   logic [FRAME_INDEX_BITS-1:0] held_start_ff, held_start_in;
   logic [HELD_END_BITS-1:0]    held_end_ff, held_end_in;
   logic                        close_done_ff, close_done_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   result_type                  rsp_ff, rsp_in;

   logic                        slot_free;
   logic [COUNT_BITS-1:0]       seg_len;
   logic                        keep;
   logic [CMP_BITS-1:0]         begin_ext;
   logic [CMP_BITS-1:0]         pad_ext;
   logic [CMP_BITS-1:0]         padded_begin;
   logic [FRAME_INDEX_BITS-1:0] pad_start;
   logic [HELD_END_BITS-1:0]    pad_end;
   logic                        merge;
   logic [HELD_END_BITS-1:0]    count_ext;
   logic [HELD_END_BITS-1:0]    clamped_end;

   assign slot_free = ~rsp_valid_ff | rsp_taken;

   // length filter and padding of the closed segment
   assign seg_len      = ev.seg_stop - {1'b0, ev.seg_begin};
   assign keep         = CMP_BITS'(seg_len) >= CMP_BITS'(cfg.min_speech_frames);
   assign begin_ext    = CMP_BITS'(ev.seg_begin);
   assign pad_ext      = CMP_BITS'(cfg.pad_frames);
   assign padded_begin = (begin_ext > pad_ext) ? begin_ext - pad_ext : '0;
   assign pad_start    = padded_begin[FRAME_INDEX_BITS-1:0];
   assign pad_end      = HELD_END_BITS'(ev.seg_stop) + HELD_END_BITS'(cfg.pad_frames);
   assign merge        = held_valid_ff && (HELD_END_BITS'(pad_start) <= held_end_ff);

   // held end clamped to the frame count for the end-of-stream flush
   assign count_ext   = HELD_END_BITS'(ev.frame_count);
   assign clamped_end = (held_end_ff < count_ext) ? held_end_ff : count_ext;

   // event step: merge/emit on a close, flush on the final frame
   always_comb begin
      held_valid_in = held_valid_ff;
      held_start_in = held_start_ff;
      held_end_in   = held_end_ff;
      close_done_in = close_done_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_taken;
      rsp_in        = rsp_ff;
      ev_pop        = 1'b0;

      if (ev_valid) begin
         if (ev.has_close && !close_done_ff) begin
            // a new kept segment that cannot merge pushes out the held one
            if (!(keep && held_valid_ff && !merge) || slot_free) begin
               if (keep) begin
                  if (merge) begin
                     held_end_in = pad_end;
                  end else begin
                     if (held_valid_ff) begin
                        rsp_valid_in              = 1'b1;
                        rsp_in.seg_start          = held_start_ff;
                        rsp_in.seg_end            = held_end_ff[COUNT_BITS-1:0];
                        rsp_in.has_segment        = 1'b1;
                        rsp_in.reaches_stream_end = 1'b0;
                        rsp_in.end_of_stream      = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_start_in = pad_start;
                     held_end_in   = pad_end;
                  end
               end
               if (ev.final_frame) begin
                  close_done_in = 1'b1;
               end else begin
                  ev_pop = 1'b1;
               end
            end
         end else if (slot_free) begin
            rsp_valid_in         = 1'b1;
            rsp_in.end_of_stream = 1'b1;
            if (held_valid_ff) begin
               rsp_in.seg_start          = held_start_ff;
               rsp_in.seg_end            = clamped_end[COUNT_BITS-1:0];
               rsp_in.has_segment        = 1'b1;
               rsp_in.reaches_stream_end = clamped_end == count_ext;
            end else begin
               rsp_in.seg_start          = '0;
               rsp_in.seg_end            = '0;
               rsp_in.has_segment        = 1'b0;
               rsp_in.reaches_stream_end = 1'b0;
            end
            held_valid_in = 1'b0;
            held_start_in = '0;
            held_end_in   = '0;
            close_done_in = 1'b0;
            ev_pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_start_ff <= '0;
         held_end_ff   <= '0;
         close_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_start_ff <= held_start_in;
         held_end_ff   <= held_end_in;
         close_done_ff <= close_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### dv/tb.sv
module tb;
   import ssh_pkg::*;

   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 8;
   localparam int SETTLE_CYCLES   = 16;
   localparam int STALL_LIMIT     = 5000;
   localparam int IDLE_PERCENT    = 13;

   localparam logic [CSR_DATA_BITS-1:0] PROB_ONE    = 16'h8000;
   localparam logic [CSR_DATA_BITS-1:0] PROB_MAX    = 16'hFFFF;
   localparam logic [COUNT_BITS-1:0]    FRAME_LIMIT = COUNT_BITS'(1) << FRAME_INDEX_BITS;

   localparam result_type NO_SEGMENT = '{'0, '0, 1'b0, 1'b0, 1'b1};

   // kinds of probability runs inside a stream
   typedef enum int {RUN_SPEECH, RUN_MIDDLE, RUN_QUIET, RUN_EDGE, RUN_NOISE} run_kind_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] prob;
      logic                     fin;
      logic [7:0]               reps;
      logic                     typed;
      result_type               want;
   } frame_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [CSR_DATA_BITS-1:0]    req_probability = '0;
   logic                        req_final_frame = 1'b0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [FRAME_INDEX_BITS-1:0] rsp_seg_start;
   logic [COUNT_BITS-1:0]       rsp_seg_end;
   logic                        rsp_has_segment;
   logic                        rsp_reaches_stream_end;
   logic                        rsp_end_of_stream;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_data = '0;

   bit steady = 1'b0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   result_type segments_due[$];

   // segmenter copy: settings and stream state
   cfg_type                     cfg_now;
   logic [COUNT_BITS-1:0]       frames_seen;
   logic                        in_talk, in_quiet, held_ok;
   logic [FRAME_INDEX_BITS-1:0] talk_from, quiet_from, held_from;
   logic [HELD_END_BITS-1:0]    held_to;

   speech_segment_hysteresis_padder uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_probability        (req_probability),
      .req_final_frame        (req_final_frame),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_seg_start          (rsp_seg_start),
      .rsp_seg_end            (rsp_seg_end),
      .rsp_has_segment        (rsp_has_segment),
      .rsp_reaches_stream_end (rsp_reaches_stream_end),
      .rsp_end_of_stream      (rsp_end_of_stream),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- segmenter

   task automatic forget_stream();
      frames_seen = '0;
      in_talk     = 1'b0;
      in_quiet    = 1'b0;
      held_ok     = 1'b0;
      talk_from   = '0;
      quiet_from  = '0;
      held_from   = '0;
      held_to     = '0;
   endtask

   // drop short speech, pad it, merge with the held segment or push the held one out
   task automatic keep_speech(input logic [FRAME_INDEX_BITS-1:0] s,
                              input logic [COUNT_BITS-1:0] e);
      logic [COUNT_BITS-1:0]    span;
      logic [HELD_END_BITS-1:0] wide_s, wide_pad, pad_s, pad_e;
      result_type               out;
      span     = e - COUNT_BITS'(s);
      wide_s   = HELD_END_BITS'(s);
      wide_pad = HELD_END_BITS'(cfg_now.pad_frames);
      pad_s    = (wide_s > wide_pad) ? wide_s - wide_pad : '0;
      pad_e    = HELD_END_BITS'(e) + wide_pad;
      if (span >= cfg_now.min_speech_frames) begin
         if (held_ok && pad_s <= held_to) begin
            held_to = pad_e;
         end else begin
            if (held_ok) begin
               out = '0;
               out.seg_start   = held_from;
               out.seg_end     = held_to[COUNT_BITS-1:0];
               out.has_segment = 1'b1;
               segments_due.push_back(out);
            end
            held_ok   = 1'b1;
            held_from = pad_s[FRAME_INDEX_BITS-1:0];
            held_to   = pad_e;
         end
      end
   endtask

   task automatic segment_frame(input logic [CSR_DATA_BITS-1:0] prob, input logic fin);
      logic [FRAME_INDEX_BITS-1:0] f;
      logic [COUNT_BITS-1:0]       fc, end_at;
      result_type                  out;
      // frame counter saturates at the limit
      if (frames_seen < FRAME_LIMIT) begin
         f = frames_seen[FRAME_INDEX_BITS-1:0];
         frames_seen = frames_seen + 1'b1;
      end else begin
         f = '1;
         frames_seen = FRAME_LIMIT;
      end

      // hysteresis and hangover
      if (!in_talk) begin
         if (prob >= cfg_now.start_threshold) begin
            in_talk   = 1'b1;
            talk_from = f;
         end
      end else if (prob >= cfg_now.start_threshold) begin
         in_quiet = 1'b0;
      end else if (!in_quiet) begin
         if (prob < cfg_now.release_threshold) begin
            in_quiet   = 1'b1;
            quiet_from = f;
         end
      end else if ((f - quiet_from) >= cfg_now.min_silence_frames) begin
         keep_speech(talk_from, COUNT_BITS'(quiet_from));
         in_talk  = 1'b0;
         in_quiet = 1'b0;
      end

      // last frame: close, flush held segment or send an empty end record
      if (fin) begin
         fc = frames_seen;
         if (in_talk) begin
            keep_speech(talk_from, in_quiet ? COUNT_BITS'(quiet_from) : fc);
            in_talk  = 1'b0;
            in_quiet = 1'b0;
         end
         out = NO_SEGMENT;
         if (held_ok) begin
            end_at = (held_to < HELD_END_BITS'(fc)) ? held_to[COUNT_BITS-1:0] : fc;
            out.seg_start          = held_from;
            out.seg_end            = end_at;
            out.has_segment        = 1'b1;
            out.reaches_stream_end = (end_at == fc);
         end
         segments_due.push_back(out);
         forget_stream();
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic go_quiet();
      @(negedge clock);
      req_push  <= 1'b0;
      csr_valid <= 1'b0;
   endtask

   task automatic drain(input int settle);
      go_quiet();
      while (segments_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] ix,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (ix)
         CSR_START_THRESHOLD:   cfg_now.start_threshold    = val;
         CSR_RELEASE_THRESHOLD: cfg_now.release_threshold  = val;
         CSR_MIN_SILENCE:       cfg_now.min_silence_frames = val;
         CSR_MIN_SPEECH:        cfg_now.min_speech_frames  = val;
         CSR_PAD:               cfg_now.pad_frames         = val;
         default: ;
      endcase
   endtask

   // typed rows replace whatever the segmenter predicted for that request
   task automatic send_frame(input logic [CSR_DATA_BITS-1:0] prob, input logic fin,
                             input logic typed, input result_type want);
      int before_n;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push        <= 1'b1;
      req_probability <= prob;
      req_final_frame <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      before_n = segments_due.size();
      segment_frame(prob, fin);
      if (typed) begin
         while (segments_due.size() > before_n) void'(segments_due.pop_back());
         segments_due.push_back(want);
      end
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_probability(input run_kind_type kind);
      logic [CSR_DATA_BITS-1:0] lo, hi;
      lo = cfg_now.release_threshold;
      hi = cfg_now.start_threshold;
      case (kind)
         RUN_SPEECH: return CSR_DATA_BITS'($urandom_range(PROB_MAX, hi));
         RUN_MIDDLE: if (hi > lo) return CSR_DATA_BITS'($urandom_range(hi - 1'b1, lo));
                     else return CSR_DATA_BITS'($urandom);
         RUN_QUIET:  if (lo != 0) return CSR_DATA_BITS'($urandom_range(lo - 1'b1, 0));
                     else return CSR_DATA_BITS'($urandom);
         RUN_EDGE:
            case ($urandom_range(5))
               0: return '0;
               1: return PROB_ONE;
               2: return PROB_MAX;
               3: return hi;
               4: return hi - 1'b1;
               default: return lo;
            endcase
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   // streams of speech / middle / quiet / edge / noise runs, a few short or cut ones
   task automatic run_phase(input int items);
      int           sent, run_left, stream_left, pick;
      run_kind_type kind;
      logic         fin;
      sent = 0;
      run_left = 0;
      stream_left = 0;
      kind = RUN_NOISE;
      while (sent < items) begin
         if (stream_left == 0)
            stream_left = ($urandom_range(9) == 0) ? $urandom_range(3, 1)
                                                   : $urandom_range(80, 5);
         if (run_left == 0) begin
            pick = $urandom_range(99);
            kind = (pick < 40) ? RUN_SPEECH :
                   (pick < 55) ? RUN_MIDDLE :
                   (pick < 80) ? RUN_QUIET  :
                   (pick < 88) ? RUN_EDGE   : RUN_NOISE;
            run_left = $urandom_range(14, 1);
         end
         fin = (stream_left == 1) || ($urandom_range(99) == 0);
         send_frame(pick_probability(kind), fin, 1'b0, NO_SEGMENT);
         sent++;
         run_left--;
         stream_left = fin ? 0 : stream_left - 1;
         // halfway through, the sender holds off until every result is back
         if (sent == items / 2) drain(0);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) rsp_pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);

   always @(posedge clock) begin : take_result
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (segments_due.size() == 0) begin
            $display("%0t unexpected result: expected none, actual start %0d end %0d eos %0d",
                     $time, rsp_seg_start, rsp_seg_end, rsp_end_of_stream);
            mismatch_count++;
         end else begin
            want = segments_due.pop_front();
            check_field("seg_start", 32'(want.seg_start), 32'(rsp_seg_start));
            check_field("seg_end", 32'(want.seg_end), 32'(rsp_seg_end));
            check_field("has_segment", 32'(want.has_segment), 32'(rsp_has_segment));
            check_field("reaches_stream_end", 32'(want.reaches_stream_end),
                        32'(rsp_reaches_stream_end));
            check_field("end_of_stream", 32'(want.end_of_stream),
                        32'(rsp_end_of_stream));
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      frame_row_type plan [0:9];
      cfg_type       next_cfg;
      int            i, k, ph, ix;

      cfg_now = '{START_THRESHOLD_RESET, RELEASE_THRESHOLD_RESET, MIN_SILENCE_RESET,
                  MIN_SPEECH_RESET, PAD_RESET};
      forget_stream();

      // single-frame streams, shortest kept segment, one frame short of it,
      // then threshold edges with a silence open at the last frame
      plan[0] = '{16'd0, 1'b1, 8'd1, 1'b1, NO_SEGMENT};
      plan[1] = '{PROB_ONE, 1'b1, 8'd1, 1'b1, NO_SEGMENT};
      plan[2] = '{PROB_MAX, 1'b0, 8'd7, 1'b0, NO_SEGMENT};
      plan[3] = '{PROB_MAX, 1'b1, 8'd1, 1'b1, '{24'd0, 25'd8, 1'b1, 1'b1, 1'b1}};
      plan[4] = '{PROB_MAX, 1'b0, 8'd6, 1'b0, NO_SEGMENT};
      plan[5] = '{PROB_MAX, 1'b1, 8'd1, 1'b1, NO_SEGMENT};
      plan[6] = '{START_THRESHOLD_RESET, 1'b0, 8'd1, 1'b0, NO_SEGMENT};
      plan[7] = '{RELEASE_THRESHOLD_RESET, 1'b0, 8'd1, 1'b0, NO_SEGMENT};
      plan[8] = '{RELEASE_THRESHOLD_RESET - 1'b1, 1'b0, 8'd1, 1'b0, NO_SEGMENT};
      plan[9] = '{START_THRESHOLD_RESET - 1'b1, 1'b1, 8'd1, 1'b0, NO_SEGMENT};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 10; i++)
         for (k = 0; k < plan[i].reps; k++)
            send_frame(plan[i].prob, plan[i].fin, plan[i].typed, plan[i].want);

      // random phases, each under its own settings
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: next_cfg = '{START_THRESHOLD_RESET, RELEASE_THRESHOLD_RESET, MIN_SILENCE_RESET,
                            MIN_SPEECH_RESET, PAD_RESET};
            1: next_cfg = '0;
            2: next_cfg = '1;
            3: next_cfg = '{PROB_ONE, 16'd16384, 16'd2, 16'd3, 16'd1};
            4: next_cfg = '{16'd20000, 16'd5000, 16'd0, 16'd0, PROB_MAX};
            5: next_cfg = '{PROB_ONE, PROB_ONE, 16'd1, PROB_MAX, 16'd0};
            6: begin
               next_cfg.start_threshold    = CSR_DATA_BITS'($urandom_range(40000, 0));
               next_cfg.release_threshold  =
                  CSR_DATA_BITS'($urandom_range(next_cfg.start_threshold, 0));
               next_cfg.min_silence_frames = CSR_DATA_BITS'($urandom_range(15, 0));
               next_cfg.min_speech_frames  = CSR_DATA_BITS'($urandom_range(12, 0));
               next_cfg.pad_frames         = CSR_DATA_BITS'($urandom_range(8, 0));
            end
            default: begin
               // short hangover against wide padding so segments merge
               next_cfg.start_threshold    = CSR_DATA_BITS'($urandom_range(PROB_ONE, 1000));
               next_cfg.release_threshold  =
                  CSR_DATA_BITS'($urandom_range(next_cfg.start_threshold, 0));
               next_cfg.min_silence_frames = CSR_DATA_BITS'($urandom_range(6, 0));
               next_cfg.min_speech_frames  = CSR_DATA_BITS'($urandom_range(6, 0));
               next_cfg.pad_frames         = CSR_DATA_BITS'($urandom_range(20, 4));
            end
         endcase

         drain(SETTLE_CYCLES);
         write_reg(CSR_START_THRESHOLD, next_cfg.start_threshold);
         write_reg(CSR_RELEASE_THRESHOLD, next_cfg.release_threshold);
         write_reg(CSR_MIN_SILENCE, next_cfg.min_silence_frames);
         write_reg(CSR_MIN_SPEECH, next_cfg.min_speech_frames);
         write_reg(CSR_PAD, next_cfg.pad_frames);
         // indexes past the last register are ignored
         if (ph == 6)
            for (ix = CSR_PAD + 1; ix < (1 << CSR_INDEX_BITS); ix++)
               write_reg(CSR_INDEX_BITS'(ix), CSR_DATA_BITS'($urandom));
         go_quiet();

         steady = (ph == 3);
         run_phase(ITEMS_PER_PHASE);
         steady = 1'b0;
      end

      drain(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_front.sv
hw/rtl/ssh_queue.sv
hw/rtl/ssh_back.sv
hw/rtl/speech_segment_hysteresis_padder.sv
dv/tb.sv
